// ===== sv/owb_pkg.sv =====
// Shared types, constants and helpers for the one-wire bus master.
package owb_pkg;

	localparam int COUNT_BITS = 10;
	localparam int REG_W      = 10;
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = 3;
	localparam int DATA_W     = 8;
	localparam int BIT_IDX_W  = 4;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [REG_W-1:0]      reg_t;

	localparam count_t CNT_MAX = '1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_PRE,
		PH_RST_LOW,
		PH_RST_SAMPLE,
		PH_RST_TAIL,
		PH_W_START,
		PH_W_HOLD,
		PH_W_GAP,
		PH_R_START,
		PH_R_SAMPLE,
		PH_R_WAIT
	} phase_t;

	typedef enum logic [1:0] {
		FN_TICK,
		FN_RESET,
		FN_WRITE,
		FN_READ
	} func_t;

	typedef enum logic [REG_IDX_W-1:0] {
		RG_PRE_RESET,
		RG_RESET_LOW,
		RG_PRESENCE_WAIT,
		RG_RESET_TAIL,
		RG_START_LOW,
		RG_SLOT,
		RG_SAMPLE,
		RG_BYTE_GAP
	} reg_idx_t;

	localparam reg_t REG_RESET [NUM_REGS] = '{
		REG_W'(12), REG_W'(80), REG_W'(10), REG_W'(5),
		REG_W'(1),  REG_W'(5),  REG_W'(1),  REG_W'(5)
	};

	// sequencer state that moves through phase transitions
	typedef struct packed {
		phase_t                phase;
		logic [BIT_IDX_W-1:0]  bit_idx;
		logic [DATA_W-1:0]     shift;
		logic [DATA_W-1:0]     rd;
		logic                  done;
	} seq_t;

	function automatic count_t clip_count(reg_t v);
		if (32'(v) > 32'(CNT_MAX))
			return CNT_MAX;
		return COUNT_BITS'(v);
	endfunction

	function automatic reg_idx_t reg_of(phase_t p);
		case (p)
			PH_RST_PRE:    return RG_PRE_RESET;
			PH_RST_LOW:    return RG_RESET_LOW;
			PH_RST_SAMPLE: return RG_PRESENCE_WAIT;
			PH_RST_TAIL:   return RG_RESET_TAIL;
			PH_W_START:    return RG_START_LOW;
			PH_W_HOLD:     return RG_SLOT;
			PH_W_GAP:      return RG_BYTE_GAP;
			PH_R_START:    return RG_START_LOW;
			PH_R_SAMPLE:   return RG_SAMPLE;
			PH_R_WAIT:     return RG_SLOT;
			default:       return RG_PRE_RESET;
		endcase
	endfunction

endpackage

// ===== sv/one_wire_bus_master.sv =====
// One-wire bus master: input register, phase sequencer, result register.
// An accepted item goes through the input register, then the result register.
// Throughput: one item per cycle unless out_stall holds the result register;
// the sequencer update and the zero-length phase skip fit between the two registers.
// Reset (arst_n low, asynchronous): bus released, sequencer idle, timing
// registers back to their defaults, both pipeline stages empty.
module one_wire_bus_master
	import owb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [DATA_W-1:0]    write_data,
	input  logic                 line_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 drive_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 present,
	output logic [DATA_W-1:0]    read_data,
	output logic                 rejected,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	reg_t                cfg_q [NUM_REGS];
	logic                valid_s1;
	func_t               func_s1;
	logic [DATA_W-1:0]   wdata_s1;
	logic                level_s1;
	seq_t                seq_q;
	count_t              tc_q;
	logic                pres_q;
	logic                out_valid_q;
	logic                drive_q;
	logic                busy_q;
	logic                done_q;
	logic                rej_q;

	logic                out_ready;
	logic                adv;
	logic [NUM_REGS-1:0] zero;
	count_t              d_cur;
	seq_t                cur;
	seq_t                nxt;
	count_t              tc_n;
	count_t              tc_inc;
	logic                pres_n;
	logic                rej_n;

	// skip plain phases of zero length, closed form
	function automatic seq_t settle(seq_t s, logic [NUM_REGS-1:0] z);
		seq_t r;
		r = s;
		case (r.phase)
			PH_RST_PRE: begin
				if (z[RG_PRE_RESET])
					r.phase = z[RG_RESET_LOW] ? PH_RST_SAMPLE : PH_RST_LOW;
			end
			PH_RST_LOW: begin
				if (z[RG_RESET_LOW])
					r.phase = PH_RST_SAMPLE;
			end
			PH_RST_TAIL: begin
				if (z[RG_RESET_TAIL]) begin
					r.phase = PH_IDLE;
					r.done  = 1'b1;
				end
			end
			PH_W_START, PH_W_HOLD: begin
				if ((r.phase == PH_W_HOLD || z[RG_START_LOW]) && z[RG_SLOT]) begin
					if (z[RG_START_LOW]) begin
						// every remaining slot collapses
						r.shift   = r.shift >> (BIT_IDX_W'(DATA_W) - r.bit_idx);
						r.bit_idx = BIT_IDX_W'(DATA_W);
					end else begin
						r.shift   = r.shift >> 1;
						r.bit_idx = r.bit_idx + BIT_IDX_W'(1);
					end
					if (r.bit_idx >= BIT_IDX_W'(DATA_W)) begin
						if (z[RG_BYTE_GAP]) begin
							r.phase = PH_IDLE;
							r.done  = 1'b1;
						end else begin
							r.phase = PH_W_GAP;
						end
					end else begin
						r.phase = PH_W_START;
					end
				end else if (r.phase == PH_W_START && z[RG_START_LOW]) begin
					r.phase = PH_W_HOLD;
				end
			end
			PH_W_GAP: begin
				if (z[RG_BYTE_GAP]) begin
					r.phase = PH_IDLE;
					r.done  = 1'b1;
				end
			end
			PH_R_START: begin
				if (z[RG_START_LOW])
					r.phase = PH_R_SAMPLE;
			end
			PH_R_WAIT: begin
				if (z[RG_SLOT]) begin
					r.bit_idx = r.bit_idx + BIT_IDX_W'(1);
					if (r.bit_idx >= BIT_IDX_W'(DATA_W)) begin
						r.rd    = r.shift;
						r.phase = PH_IDLE;
						r.done  = 1'b1;
					end else begin
						r.phase = z[RG_START_LOW] ? PH_R_SAMPLE : PH_R_START;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic seq_t next_phase(seq_t s);
		seq_t r;
		r = s;
		case (r.phase)
			PH_RST_PRE:    r.phase = PH_RST_LOW;
			PH_RST_LOW:    r.phase = PH_RST_SAMPLE;
			PH_RST_SAMPLE: r.phase = PH_RST_TAIL;
			PH_RST_TAIL: begin
				r.phase = PH_IDLE;
				r.done  = 1'b1;
			end
			PH_W_START:    r.phase = PH_W_HOLD;
			PH_W_HOLD: begin
				r.shift   = r.shift >> 1;
				r.bit_idx = r.bit_idx + BIT_IDX_W'(1);
				r.phase   = (r.bit_idx >= BIT_IDX_W'(DATA_W)) ? PH_W_GAP : PH_W_START;
			end
			PH_W_GAP: begin
				r.phase = PH_IDLE;
				r.done  = 1'b1;
			end
			PH_R_START:    r.phase = PH_R_SAMPLE;
			PH_R_SAMPLE:   r.phase = PH_R_WAIT;
			PH_R_WAIT: begin
				r.bit_idx = r.bit_idx + BIT_IDX_W'(1);
				if (r.bit_idx >= BIT_IDX_W'(DATA_W)) begin
					r.rd    = r.shift;
					r.phase = PH_IDLE;
					r.done  = 1'b1;
				end else begin
					r.phase = PH_R_START;
				end
			end
			default:       r.phase = PH_IDLE;
		endcase
		return r;
	endfunction

	function automatic logic drive_of(seq_t s);
		case (s.phase)
			PH_RST_LOW, PH_W_START, PH_R_START: return 1'b1;
			PH_W_HOLD:                          return ~s.shift[0];
			default:                            return 1'b0;
		endcase
	endfunction

	assign out_ready = ~out_valid_q | ~out_stall;
	assign adv       = valid_s1 & out_ready;
	assign in_stall  = valid_s1 & ~out_ready;

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++)
			zero[i] = (cfg_q[i] == '0);
	end

	assign d_cur = clip_count(cfg_q[reg_of(seq_q.phase)]);

	always_comb begin
		cur      = seq_q;
		cur.done = 1'b0;
		nxt      = cur;
		tc_n     = tc_q;
		tc_inc   = tc_q + count_t'(1);
		pres_n   = pres_q;
		rej_n    = 1'b0;
		if (func_s1 != FN_TICK) begin
			if (cur.phase != PH_IDLE) begin
				rej_n = 1'b1;
			end else begin
				nxt.bit_idx = '0;
				case (func_s1)
					FN_RESET: begin
						pres_n    = 1'b0;
						nxt.phase = PH_RST_PRE;
					end
					FN_WRITE: begin
						nxt.shift = wdata_s1;
						nxt.phase = PH_W_START;
					end
					FN_READ: begin
						nxt.shift = '0;
						nxt.phase = PH_R_START;
					end
					default: ;
				endcase
				nxt  = settle(nxt, zero);
				tc_n = '0;
			end
		end else if (cur.phase != PH_IDLE) begin
			if (cur.phase == PH_RST_SAMPLE || cur.phase == PH_R_SAMPLE) begin
				if (tc_q >= d_cur) begin
					if (cur.phase == PH_RST_SAMPLE)
						pres_n = ~level_s1;
					else
						nxt.shift = {level_s1, cur.shift[DATA_W-1:1]};
					nxt  = settle(next_phase(nxt), zero);
					tc_n = '0;
				end else begin
					tc_n = tc_inc;
				end
			end else if (tc_inc >= d_cur) begin
				nxt  = settle(next_phase(nxt), zero);
				tc_n = '0;
			end else begin
				tc_n = tc_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				cfg_q[i] <= REG_RESET[i];
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			seq_q       <= '{phase: PH_IDLE, default: '0};
			tc_q        <= '0;
			pres_q      <= 1'b0;
			drive_q     <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			rej_q       <= 1'b0;
		end else begin
			if (!valid_s1 || out_ready)
				valid_s1 <= in_valid;
			if (out_ready)
				out_valid_q <= valid_s1;
			if (adv) begin
				seq_q   <= nxt;
				tc_q    <= tc_n;
				pres_q  <= pres_n;
				drive_q <= drive_of(nxt);
				busy_q  <= (nxt.phase != PH_IDLE);
				done_q  <= nxt.done;
				rej_q   <= rej_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func_t'(func);
			wdata_s1 <= write_data;
			level_s1 <= line_level;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_low = drive_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign present   = pres_q;
	assign read_data = seq_q.rd;
	assign rejected  = rej_q;

endmodule

// ===== tb/owb_result_checker.sv =====
// Checker for the one-wire bus master: predicts each result beat and compares it.
`timescale 1ns / 1ps

module owb_result_checker
	import owb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [DATA_W-1:0]    write_data,
	input  logic                 line_level,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 drive_low,
	input  logic                 busy_res,
	input  logic                 done_res,
	input  logic                 present,
	input  logic [DATA_W-1:0]    read_data,
	input  logic                 rejected,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   outstanding,
	output int                   beats_checked,
	output int                   ops_done,
	output int                   cmds_refused
);

	localparam int BYTE_BITS = 8;

	typedef struct packed {
		logic              drive;
		logic              busy;
		logic              done;
		logic              pres;
		logic [DATA_W-1:0] rdata;
		logic              rej;
	} bus_result_t;

	reg_t                 timing [NUM_REGS];
	phase_t               ph;
	count_t               ticks;
	logic [BIT_IDX_W-1:0] bit_n;
	logic [DATA_W-1:0]    shreg;
	logic [DATA_W-1:0]    rbyte;
	logic                 pres_f;
	logic                 drv;
	logic                 fin;

	bus_result_t expected_beats [$];
	bus_result_t want;

	function automatic count_t phase_len(phase_t p);
		reg_t v;
		case (p)
			PH_RST_PRE:             v = timing[RG_PRE_RESET];
			PH_RST_LOW:             v = timing[RG_RESET_LOW];
			PH_RST_SAMPLE:          v = timing[RG_PRESENCE_WAIT];
			PH_RST_TAIL:            v = timing[RG_RESET_TAIL];
			PH_W_START, PH_R_START: v = timing[RG_START_LOW];
			PH_W_HOLD, PH_R_WAIT:   v = timing[RG_SLOT];
			PH_W_GAP:               v = timing[RG_BYTE_GAP];
			PH_R_SAMPLE:            v = timing[RG_SAMPLE];
			default:                v = '0;
		endcase
		if (int'(v) >= (1 << COUNT_BITS))
			return '1;
		return count_t'(v);
	endfunction

	function automatic bit is_sample_ph(phase_t p);
		return p == PH_RST_SAMPLE || p == PH_R_SAMPLE;
	endfunction

	function automatic void update_drive();
		case (ph)
			PH_RST_LOW, PH_W_START, PH_R_START: drv = 1'b1;
			PH_W_HOLD:                          drv = ~shreg[0];
			default:                            drv = 1'b0;
		endcase
	endfunction

	function automatic void step_phase();
		case (ph)
			PH_RST_PRE:    ph = PH_RST_LOW;
			PH_RST_LOW:    ph = PH_RST_SAMPLE;
			PH_RST_SAMPLE: ph = PH_RST_TAIL;
			PH_RST_TAIL: begin
				ph  = PH_IDLE;
				fin = 1'b1;
			end
			PH_W_START:    ph = PH_W_HOLD;
			PH_W_HOLD: begin
				shreg = shreg >> 1;
				bit_n = bit_n + BIT_IDX_W'(1);
				ph    = (bit_n >= BIT_IDX_W'(BYTE_BITS)) ? PH_W_GAP : PH_W_START;
			end
			PH_W_GAP: begin
				ph  = PH_IDLE;
				fin = 1'b1;
			end
			PH_R_START:    ph = PH_R_SAMPLE;
			PH_R_SAMPLE:   ph = PH_R_WAIT;
			PH_R_WAIT: begin
				bit_n = bit_n + BIT_IDX_W'(1);
				if (bit_n >= BIT_IDX_W'(BYTE_BITS)) begin
					rbyte = shreg;
					ph    = PH_IDLE;
					fin   = 1'b1;
				end else begin
					ph = PH_R_START;
				end
			end
			default:       ph = PH_IDLE;
		endcase
		ticks = '0;
		update_drive();
	endfunction

	// zero-length plain phases pass within the same beat
	function automatic void skip_empty();
		ticks = '0;
		update_drive();
		while (ph != PH_IDLE && !is_sample_ph(ph) && phase_len(ph) == '0)
			step_phase();
	endfunction

	function automatic bus_result_t predict_bus_step(func_t f, logic [DATA_W-1:0] wd,
			logic lvl);
		bus_result_t r;
		logic        rej;
		rej = 1'b0;
		fin = 1'b0;
		if (f != FN_TICK) begin
			if (ph != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				bit_n = '0;
				case (f)
					FN_RESET: begin
						pres_f = 1'b0;
						ph     = PH_RST_PRE;
					end
					FN_WRITE: begin
						shreg = wd;
						ph    = PH_W_START;
					end
					default: begin
						shreg = '0;
						ph    = PH_R_START;
					end
				endcase
				skip_empty();
			end
		end else if (ph != PH_IDLE) begin
			if (is_sample_ph(ph)) begin
				if (ticks >= phase_len(ph)) begin
					if (ph == PH_RST_SAMPLE)
						pres_f = ~lvl;
					else
						shreg = {lvl, shreg[DATA_W-1:1]};
					step_phase();
					skip_empty();
				end else begin
					ticks = ticks + count_t'(1);
				end
			end else begin
				ticks = ticks + count_t'(1);
				if (ticks >= phase_len(ph)) begin
					step_phase();
					skip_empty();
				end
			end
		end
		r.drive = drv;
		r.busy  = (ph != PH_IDLE);
		r.done  = fin;
		r.pres  = pres_f;
		r.rdata = rbyte;
		r.rej   = rej;
		return r;
	endfunction

	task automatic report(string msg);
		fail_count++;
		if (fail_count <= 100)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp_v);
		if (got !== exp_v)
			report($sformatf("beat %0d %s got %0h expected %0h", beats_checked, name, got,
				exp_v));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				timing[i] = REG_RESET[i];
			ph     = PH_IDLE;
			ticks  = '0;
			bit_n  = '0;
			shreg  = '0;
			rbyte  = '0;
			pres_f = 1'b0;
			drv    = 1'b0;
			fin    = 1'b0;
			expected_beats.delete();
			fail_count    = 0;
			beats_checked = 0;
			ops_done      = 0;
			cmds_refused  = 0;
			outstanding  <= 0;
		end else begin
			if (cfg_we)
				timing[cfg_index] = cfg_data;
			if (in_valid && !in_stall)
				expected_beats.push_back(predict_bus_step(func_t'(func), write_data, line_level));
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					want = expected_beats.pop_front();
					check_field("drive_low", DATA_W'(drive_low), DATA_W'(want.drive));
					check_field("busy_res", DATA_W'(busy_res), DATA_W'(want.busy));
					check_field("done_res", DATA_W'(done_res), DATA_W'(want.done));
					check_field("present", DATA_W'(present), DATA_W'(want.pres));
					check_field("read_data", read_data, want.rdata);
					check_field("rejected", DATA_W'(rejected), DATA_W'(want.rej));
					if (want.done)
						ops_done++;
					if (want.rej)
						cmds_refused++;
				end
				beats_checked++;
			end
			outstanding <= expected_beats.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the one-wire bus master testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import owb_pkg::*;

	typedef enum logic [1:0] {LV_LOW, LV_HIGH, LV_RANDOM} level_mode_t;
	typedef enum logic [1:0] {ST_NONE, ST_LIGHT, ST_HEAVY, ST_TOGGLE} stall_mode_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic [1:0]           func       = FN_TICK;
	logic [DATA_W-1:0]    write_data = '0;
	logic                 line_level = 1'b0;
	logic                 out_stall  = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index  = RG_PRE_RESET;
	logic [REG_W-1:0]     cfg_data   = '0;

	logic              in_stall;
	logic              out_valid;
	logic              drive_low;
	logic              busy_res;
	logic              done_res;
	logic              present;
	logic [DATA_W-1:0] read_data;
	logic              rejected;

	int fail_count;
	int outstanding;
	int beats_checked;
	int ops_done;
	int cmds_refused;

	int          tim [NUM_REGS];
	reg_t        next_tim [NUM_REGS];
	int          burst_left = 0;
	int          items_sent = 0;
	int          settings   = 0;
	stall_mode_t stall_mode = ST_NONE;
	int          stall_span = 0;

	always #2 clk = ~clk;

	one_wire_bus_master dut (.*);

	owb_result_checker chk (.*);

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(ST_NONE, ST_TOGGLE));
			stall_span <= $urandom_range(20, 300);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			ST_NONE:  out_stall <= 1'b0;
			ST_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			ST_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:  out_stall <= ~out_stall;
		endcase
	end

	function automatic int op_len(func_t f);
		case (f)
			FN_RESET: return tim[RG_PRE_RESET] + tim[RG_RESET_LOW] + tim[RG_PRESENCE_WAIT] + 1 +
				tim[RG_RESET_TAIL];
			FN_WRITE: return 8 * (tim[RG_START_LOW] + tim[RG_SLOT]) + tim[RG_BYTE_GAP];
			FN_READ:  return 8 * (tim[RG_START_LOW] + tim[RG_SAMPLE] + 1 + tim[RG_SLOT]);
			default:  return 0;
		endcase
	endfunction

	function automatic reg_t min_of(reg_idx_t r);
		case (r)
			RG_RESET_LOW, RG_PRESENCE_WAIT, RG_START_LOW, RG_SLOT: return reg_t'(1);
			default: return '0;
		endcase
	endfunction

	function automatic reg_t rand_timing(reg_idx_t r);
		int hi;
		hi = ($urandom_range(0, 7) == 0) ? 40 : 6;
		return reg_t'($urandom_range(int'(min_of(r)), hi));
	endfunction

	function automatic logic pick_level(level_mode_t lm);
		case (lm)
			LV_LOW:  return 1'b0;
			LV_HIGH: return 1'b1;
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic send(func_t f, logic [DATA_W-1:0] d, logic lvl);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
		end
		burst_left--;
		in_valid   <= 1'b1;
		func       <= f;
		write_data <= d;
		line_level <= lvl;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// wait until every expected result has been compared; leave some margin
	task automatic drain();
		in_valid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_timing();
		drain();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= next_tim[i];
			tim[i]     = int'(next_tim[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	// command, then the ticks it needs; noisy runs add refused commands,
	// cut-short sequences and idle ticks
	task automatic run_op(func_t f, logic [DATA_W-1:0] d, level_mode_t lm, bit noisy);
		int n;
		n = op_len(f);
		send(f, d, 1'($urandom_range(0, 1)));
		for (int k = 0; k < n; k++) begin
			if (noisy && $urandom_range(0, 24) == 0)
				send(func_t'($urandom_range(FN_RESET, FN_READ)), DATA_W'($urandom),
					1'($urandom_range(0, 1)));
			if (noisy && n < 1000 && $urandom_range(0, 299) == 0)
				break;
			send(FN_TICK, DATA_W'($urandom), pick_level(lm));
		end
		if (noisy)
			repeat ($urandom_range(0, 3))
				send(FN_TICK, DATA_W'($urandom), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int mark;
		for (int i = 0; i < NUM_REGS; i++)
			tim[i] = int'(REG_RESET[i]);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(FN_TICK, 8'h00, 1'b0);
		send(FN_TICK, 8'hFF, 1'b1);

		for (int i = 0; i < NUM_REGS; i++)
			next_tim[i] = min_of(reg_idx_t'(i));
		load_timing();
		run_op(FN_RESET, 8'h00, LV_LOW, 1'b0);
		send(FN_RESET, 8'h00, 1'b0);
		for (int f = FN_RESET; f <= FN_READ; f++)
			send(func_t'(f), 8'hFF, 1'b1);
		repeat (op_len(FN_RESET)) send(FN_TICK, 8'h5A, 1'b1);
		run_op(FN_WRITE, 8'h00, LV_RANDOM, 1'b0);
		run_op(FN_WRITE, 8'hFF, LV_RANDOM, 1'b0);
		run_op(FN_WRITE, 8'hA5, LV_RANDOM, 1'b0);
		run_op(FN_READ, 8'h00, LV_HIGH, 1'b0);
		run_op(FN_READ, 8'hFF, LV_LOW, 1'b0);
		run_op(FN_READ, 8'h3C, LV_RANDOM, 1'b0);

		for (int s = 0; s < 6; s++) begin
			for (int i = 0; i < NUM_REGS; i++)
				next_tim[i] = (s == 0) ? REG_RESET[i] : rand_timing(reg_idx_t'(i));
			load_timing();
			mark = items_sent;
			while (items_sent - mark < 120)
				run_op(func_t'($urandom_range(FN_RESET, FN_READ)), DATA_W'($urandom),
					LV_RANDOM, 1'b1);
		end

		// one full-length phase at the top of the counter range
		for (int i = 0; i < NUM_REGS; i++)
			next_tim[i] = min_of(reg_idx_t'(i));
		next_tim[RG_RESET_LOW] = '1;
		load_timing();
		run_op(FN_RESET, DATA_W'($urandom), LV_RANDOM, 1'b1);
		drain();

		$display("Sent %0d beats across %0d timing settings, %0d results compared.",
			items_sent, settings, beats_checked);
		$display("Bus operations finished: %0d; commands refused while busy: %0d.",
			ops_done, cmds_refused);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
